@@ rtl/core/mcc_pkg.sv @@
// shared types, constants and tables of the mayan calendar converter
package mcc_pkg;

	// biased day count u = long count + one full 2880000-day cycle, always positive
	localparam int UW      = 23;
	localparam int RecipW  = 24;
	localparam int ProdW   = UW + RecipW;

	localparam logic [UW-1:0] DaysBaktun = 23'd144000;
	localparam logic [UW-1:0] DaysKatun  = 23'd7200;
	localparam logic [UW-1:0] DaysTun    = 23'd360;
	localparam logic [UW-1:0] DaysUinal  = 23'd20;
	localparam logic [UW-1:0] LcSpan     = 23'd2880000;
	localparam logic [UW-1:0] EpochOff   = 23'd1137142;

	// day number to biased count, and the same for the digit sum
	localparam logic [UW-1:0] BiasDay = LcSpan + EpochOff;
	localparam logic [UW-1:0] BiasDig = LcSpan;
	// tzolkin trecena aligns to u - 3, haab year to u + 198
	localparam logic [UW-1:0] TzAlign   = 23'd3;
	localparam logic [UW-1:0] HaabAlign = 23'd198;
	localparam logic [UW-1:0] LcLimit   = LcSpan + LcSpan;

	// reciprocals for exact floor division of any 23-bit value
	localparam int Sh20    = 28;
	localparam int Sh13    = 27;
	localparam int Sh360   = 32;
	localparam int Sh365   = 32;
	localparam int Sh7200  = 36;
	localparam int Sh93600 = 40;
	localparam int Sh144k  = 41;

	localparam logic [RecipW-1:0] Rcp20    = 24'(((64'd1 << Sh20) + 64'd19) / 64'd20);
	localparam logic [RecipW-1:0] Rcp13    = 24'(((64'd1 << Sh13) + 64'd12) / 64'd13);
	localparam logic [RecipW-1:0] Rcp360   = 24'(((64'd1 << Sh360) + 64'd359) / 64'd360);
	localparam logic [RecipW-1:0] Rcp365   = 24'(((64'd1 << Sh365) + 64'd364) / 64'd365);
	localparam logic [RecipW-1:0] Rcp7200  = 24'(((64'd1 << Sh7200) + 64'd7199) / 64'd7200);
	localparam logic [RecipW-1:0] Rcp93600 =
		24'(((64'd1 << Sh93600) + 64'd93599) / 64'd93600);
	localparam logic [RecipW-1:0] Rcp144k  =
		24'(((64'd1 << Sh144k) + 64'd143999) / 64'd144000);

	// haab month from a residue below 365
	localparam int HaabSh = 16;
	localparam logic [11:0] HaabRcp = 12'd3277;

	typedef struct packed {
		logic        command;
		logic [21:0] day_number;
		logic [4:0]  baktun;
		logic [4:0]  katun;
		logic [4:0]  tun;
		logic [4:0]  uinal;
		logic [4:0]  kin;
	} mcc_in_t;

	typedef struct packed {
		logic s1;
		logic s2;
		logic s3;
		logic s4;
	} mcc_ld_t;

	typedef struct packed {
		logic [UW-1:0] u;
		logic [UW-1:0] ut;
		logic [UW-1:0] uh;
		logic [UW-1:0] uk;
		logic [21:0]   day_out;
	} mcc_s1_t;

	typedef struct packed {
		logic [ProdW-1:0] p20;
		logic [ProdW-1:0] p360;
		logic [ProdW-1:0] p7200;
		logic [ProdW-1:0] p144k;
		logic [ProdW-1:0] p13;
		logic [ProdW-1:0] p365;
		logic [ProdW-1:0] pk7200;
		logic [ProdW-1:0] pk93600;
		logic [4:0]       u_lo;
		logic [3:0]       ut_lo;
		logic [8:0]       uh_lo;
		logic [21:0]      day_out;
		logic             out_of_range;
	} mcc_s2_t;

	typedef struct packed {
		logic [21:0] day_out;
		logic [4:0]  lc_baktun;
		logic [4:0]  lc_katun;
		logic [4:0]  lc_tun;
		logic [4:0]  lc_uinal;
		logic [4:0]  lc_kin;
		logic [3:0]  tzolkin_number;
		logic [8:0]  haab_res;
		logic [3:0]  katun_res;
		logic        out_of_range;
	} mcc_s3_t;

	typedef struct packed {
		logic [21:0] day_out;
		logic [4:0]  lc_baktun;
		logic [4:0]  lc_katun;
		logic [4:0]  lc_tun;
		logic [4:0]  lc_uinal;
		logic [4:0]  lc_kin;
		logic [3:0]  tzolkin_number;
		logic [4:0]  tzolkin_name;
		logic [4:0]  haab_day;
		logic [4:0]  haab_month;
		logic [3:0]  katun_ahau;
		logic        out_of_range;
	} mcc_res_t;

	// ahau number from floor((u - 1) / 7200) mod 13
	function automatic logic [3:0] ahau_of(input logic [3:0] kr);
		logic [3:0] a;
		case (kr)
			4'd0:    a = 4'd9;
			4'd1:    a = 4'd7;
			4'd2:    a = 4'd5;
			4'd3:    a = 4'd3;
			4'd4:    a = 4'd1;
			4'd5:    a = 4'd12;
			4'd6:    a = 4'd10;
			4'd7:    a = 4'd8;
			4'd8:    a = 4'd6;
			4'd9:    a = 4'd4;
			4'd10:   a = 4'd2;
			4'd11:   a = 4'd13;
			4'd12:   a = 4'd11;
			default: a = 4'd1;
		endcase
		return a;
	endfunction

endpackage

@@ rtl/core/mayan_calendar_converter_top.sv @@
// Mayan calendar converter: day number or long count in, full calendar round out
//
// Input stream s_*: s_tuser selects the source (0 = day number, 1 = long count
// digits), s_tdata carries the day number and the five digits. Output stream
// m_*: s_tdata's date as day number, long count digits, tzolkin, haab and
// katun ahau; m_tuser flags a date outside the five-digit long count.
// One result item for every input item, in order.
// Four register stages (count forming, reciprocal multipliers, residues, final
// tables) each pass one item per cycle, so a new item is taken every cycle
// while m_tready stays high.
// Each stage has its own valid bit and moves on whenever the stage after it is
// empty or moving; a stall on m_tready holds the output and fills the empty
// stages behind it before s_tready drops, and no item is lost or repeated.
// Reset clears all valid bits; the block is ready in the first cycle after it.
// There is no kept state and no configuration.
module mayan_calendar_converter_top (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	// day_number[21:0], baktun, katun, tun, uinal, kin (5 bits each), 1 pad bit
	input  logic [47:0] s_tdata,
	// command
	input  logic        s_tuser,
	output logic        m_tvalid,
	input  logic        m_tready,
	// day_out[21:0], lc_baktun, lc_katun, lc_tun, lc_uinal, lc_kin (5 each),
	// tzolkin_number (4), tzolkin_name, haab_day, haab_month (5 each),
	// katun_ahau (4), 2 pad bits
	output logic [71:0] m_tdata,
	// out_of_range
	output logic        m_tuser
);

	logic              vld_s1;
	logic              vld_s2;
	logic              vld_s3;
	logic              vld_s4;
	logic              rdy1;
	logic              rdy2;
	logic              rdy3;
	logic              rdy4;
	mcc_pkg::mcc_ld_t  ld;
	mcc_pkg::mcc_in_t  in;
	mcc_pkg::mcc_s1_t  s1;
	mcc_pkg::mcc_s2_t  s2;
	mcc_pkg::mcc_s3_t  s3;
	mcc_pkg::mcc_res_t res;

	assign rdy4 = !vld_s4 || m_tready;
	assign rdy3 = !vld_s3 || rdy4;
	assign rdy2 = !vld_s2 || rdy3;
	assign rdy1 = !vld_s1 || rdy2;

	assign s_tready = rdy1;
	assign ld.s1    = s_tvalid && rdy1;
	assign ld.s2    = vld_s1 && rdy2;
	assign ld.s3    = vld_s2 && rdy3;
	assign ld.s4    = vld_s3 && rdy4;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
		end else begin
			if (rdy1) vld_s1 <= s_tvalid;
			if (rdy2) vld_s2 <= vld_s1;
			if (rdy3) vld_s3 <= vld_s2;
			if (rdy4) vld_s4 <= vld_s3;
		end
	end

	assign in.command    = s_tuser;
	assign in.day_number = s_tdata[21:0];
	assign in.baktun     = s_tdata[26:22];
	assign in.katun      = s_tdata[31:27];
	assign in.tun        = s_tdata[36:32];
	assign in.uinal      = s_tdata[41:37];
	assign in.kin        = s_tdata[46:42];

	mcc_front u_front (
		.clk (clk),
		.in  (in),
		.ld  (ld),
		.s1  (s1)
	);

	mcc_divide u_divide (
		.clk (clk),
		.s1  (s1),
		.ld  (ld),
		.s2  (s2)
	);

	mcc_resolve u_resolve (
		.clk (clk),
		.s2  (s2),
		.ld  (ld),
		.s3  (s3)
	);

	mcc_finish u_finish (
		.clk (clk),
		.s3  (s3),
		.ld  (ld),
		.res (res)
	);

	assign m_tvalid = vld_s4;
	assign m_tuser  = res.out_of_range;
	assign m_tdata  = {2'b00, res.katun_ahau, res.haab_month, res.haab_day,
		res.tzolkin_name, res.tzolkin_number, res.lc_kin, res.lc_uinal,
		res.lc_tun, res.lc_katun, res.lc_baktun, res.day_out};

	// calendar fields stay inside their cycles
	a_cal_range: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (res.tzolkin_number >= 4'd1 && res.tzolkin_number <= 4'd13
			&& res.haab_month <= 5'd18 && (res.haab_month != 5'd18 || res.haab_day < 5'd5)
			&& res.tzolkin_name <= 5'd19))
		else $error("calendar field out of its cycle");

	// long count digits and ahau keep their bases
	a_lc_range: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (res.lc_uinal <= 5'd17 && res.lc_kin <= 5'd19 && res.lc_tun <= 5'd19
			&& res.lc_katun <= 5'd19 && res.lc_baktun <= 5'd19
			&& res.katun_ahau >= 4'd1 && res.katun_ahau <= 4'd13))
		else $error("long count digit or ahau out of range");

	// a draining output lets every stage move, so the input side is open
	a_flow: assert property (@(posedge clk) disable iff (!arst_n)
		m_tready |-> s_tready)
		else $error("input stalled while output drains");

endmodule

@@ rtl/core/mcc_front.sv @@
// stage 1: forms the biased day count from a day number or long count digits
module mcc_front (
	input  logic             clk,
	input  mcc_pkg::mcc_in_t in,
	input  mcc_pkg::mcc_ld_t ld,
	output mcc_pkg::mcc_s1_t s1
);

	logic [mcc_pkg::UW-1:0] sum;
	logic [mcc_pkg::UW-1:0] dayx;
	mcc_pkg::mcc_s1_t       nxt;

	always_comb begin
		sum = mcc_pkg::UW'(in.baktun) * mcc_pkg::DaysBaktun
			+ mcc_pkg::UW'(in.katun) * mcc_pkg::DaysKatun
			+ mcc_pkg::UW'(in.tun) * mcc_pkg::DaysTun
			+ mcc_pkg::UW'(in.uinal) * mcc_pkg::DaysUinal
			+ mcc_pkg::UW'(in.kin);
		dayx = {in.day_number[21], in.day_number};
		if (in.command) begin
			nxt.u       = sum + mcc_pkg::BiasDig;
			nxt.ut      = sum + (mcc_pkg::BiasDig - mcc_pkg::TzAlign);
			nxt.uh      = sum + (mcc_pkg::BiasDig + mcc_pkg::HaabAlign);
			nxt.uk      = sum + (mcc_pkg::BiasDig - 23'd1);
			nxt.day_out = 22'(sum - mcc_pkg::EpochOff);
		end else begin
			nxt.u       = dayx + mcc_pkg::BiasDay;
			nxt.ut      = dayx + (mcc_pkg::BiasDay - mcc_pkg::TzAlign);
			nxt.uh      = dayx + (mcc_pkg::BiasDay + mcc_pkg::HaabAlign);
			nxt.uk      = dayx + (mcc_pkg::BiasDay - 23'd1);
			nxt.day_out = in.day_number;
		end
	end

	always_ff @(posedge clk) begin
		if (ld.s1) begin
			s1 <= nxt;
		end
	end

endmodule

@@ rtl/core/mcc_divide.sv @@
// stage 2: reciprocal products for each divisor of the biased counts, range check
module mcc_divide (
	input  logic             clk,
	input  mcc_pkg::mcc_s1_t s1,
	input  mcc_pkg::mcc_ld_t ld,
	output mcc_pkg::mcc_s2_t s2
);

	mcc_pkg::mcc_s2_t nxt;

	always_comb begin
		nxt.p20     = mcc_pkg::ProdW'(s1.u) * mcc_pkg::ProdW'(mcc_pkg::Rcp20);
		nxt.p360    = mcc_pkg::ProdW'(s1.u) * mcc_pkg::ProdW'(mcc_pkg::Rcp360);
		nxt.p7200   = mcc_pkg::ProdW'(s1.u) * mcc_pkg::ProdW'(mcc_pkg::Rcp7200);
		nxt.p144k   = mcc_pkg::ProdW'(s1.u) * mcc_pkg::ProdW'(mcc_pkg::Rcp144k);
		nxt.p13     = mcc_pkg::ProdW'(s1.ut) * mcc_pkg::ProdW'(mcc_pkg::Rcp13);
		nxt.p365    = mcc_pkg::ProdW'(s1.uh) * mcc_pkg::ProdW'(mcc_pkg::Rcp365);
		nxt.pk7200  = mcc_pkg::ProdW'(s1.uk) * mcc_pkg::ProdW'(mcc_pkg::Rcp7200);
		nxt.pk93600 = mcc_pkg::ProdW'(s1.uk) * mcc_pkg::ProdW'(mcc_pkg::Rcp93600);
		nxt.u_lo    = s1.u[4:0];
		nxt.ut_lo   = s1.ut[3:0];
		nxt.uh_lo   = s1.uh[8:0];
		nxt.day_out = s1.day_out;
		// long count proper covers one span above the bias
		nxt.out_of_range = (s1.u < mcc_pkg::LcSpan) || (s1.u >= mcc_pkg::LcLimit);
	end

	always_ff @(posedge clk) begin
		if (ld.s2) begin
			s2 <= nxt;
		end
	end

endmodule

@@ rtl/core/mcc_resolve.sv @@
// stage 3: quotients from the products, digits and residues in narrow arithmetic
module mcc_resolve (
	input  logic             clk,
	input  mcc_pkg::mcc_s2_t s2,
	input  mcc_pkg::mcc_ld_t ld,
	output mcc_pkg::mcc_s3_t s3
);

	logic [4:0]       q20;
	logic [4:0]       q360;
	logic [4:0]       q7200;
	logic [5:0]       q144k;
	logic [3:0]       q13;
	logic [8:0]       q365;
	logic [3:0]       qk7200;
	logic [3:0]       qk93600;
	mcc_pkg::mcc_s3_t nxt;

	always_comb begin
		// only the low bits of each quotient reach the residues
		q20     = 5'(s2.p20 >> mcc_pkg::Sh20);
		q360    = 5'(s2.p360 >> mcc_pkg::Sh360);
		q7200   = 5'(s2.p7200 >> mcc_pkg::Sh7200);
		q144k   = 6'(s2.p144k >> mcc_pkg::Sh144k);
		q13     = 4'(s2.p13 >> mcc_pkg::Sh13);
		q365    = 9'(s2.p365 >> mcc_pkg::Sh365);
		qk7200  = 4'(s2.pk7200 >> mcc_pkg::Sh7200);
		qk93600 = 4'(s2.pk93600 >> mcc_pkg::Sh93600);

		nxt.lc_kin   = 5'(s2.u_lo - 5'(q20 * 5'd20));
		nxt.lc_uinal = 5'(q20 - 5'(q360 * 5'd18));
		nxt.lc_tun   = 5'(q360 - 5'(q7200 * 5'd20));
		nxt.lc_katun = 5'(q7200 - 5'(q144k[4:0] * 5'd20));
		// baktun count is at most 52 here
		if (q144k >= 6'd40) begin
			nxt.lc_baktun = 5'(q144k - 6'd40);
		end else if (q144k >= 6'd20) begin
			nxt.lc_baktun = 5'(q144k - 6'd20);
		end else begin
			nxt.lc_baktun = 5'(q144k);
		end
		nxt.tzolkin_number = 4'(s2.ut_lo - 4'(q13 * 4'd13)) + 4'd1;
		nxt.haab_res       = 9'(s2.uh_lo - 9'(q365 * 9'd365));
		nxt.katun_res      = 4'(qk7200 - 4'(qk93600 * 4'd13));
		nxt.day_out        = s2.day_out;
		nxt.out_of_range   = s2.out_of_range;
	end

	always_ff @(posedge clk) begin
		if (ld.s3) begin
			s3 <= nxt;
		end
	end

endmodule

@@ rtl/core/mcc_finish.sv @@
// stage 4: tzolkin name, haab day and month, katun ahau, output register
module mcc_finish (
	input  logic              clk,
	input  mcc_pkg::mcc_s3_t  s3,
	input  mcc_pkg::mcc_ld_t  ld,
	output mcc_pkg::mcc_res_t res
);

	logic [4:0]        month;
	mcc_pkg::mcc_res_t nxt;

	always_comb begin
		month = 5'((21'(s3.haab_res) * 21'(mcc_pkg::HaabRcp)) >> mcc_pkg::HaabSh);
		nxt.day_out        = s3.day_out;
		nxt.lc_baktun      = s3.lc_baktun;
		nxt.lc_katun       = s3.lc_katun;
		nxt.lc_tun         = s3.lc_tun;
		nxt.lc_uinal       = s3.lc_uinal;
		nxt.lc_kin         = s3.lc_kin;
		nxt.tzolkin_number = s3.tzolkin_number;
		// day name trails the kin digit by one
		nxt.tzolkin_name   = (s3.lc_kin == 5'd0) ? 5'd19 : s3.lc_kin - 5'd1;
		nxt.haab_month     = month;
		nxt.haab_day       = 5'(s3.haab_res - 9'(9'(month) * 9'd20));
		nxt.katun_ahau     = mcc_pkg::ahau_of(s3.katun_res);
		nxt.out_of_range   = s3.out_of_range;
	end

	always_ff @(posedge clk) begin
		if (ld.s4) begin
			res <= nxt;
		end
	end

endmodule

@@ bench/tb_mayan_calendar_converter_top.sv @@
// testbench for the mayan calendar converter: random and directed dates checked against a predictor
`timescale 1ns / 1ps

module tb_mayan_calendar_converter_top;

	localparam longint EpochDays  = 1137142;
	localparam longint BaktunDays = 144000;
	localparam longint KatunDays  = 7200;
	localparam longint TunDays    = 360;
	localparam longint UinalDays  = 20;
	localparam longint CountSpan  = 2880000;
	localparam int     RandomDates = 2000;
	localparam int     HoldCycles  = 80;
	localparam int     DrainCycles = 16;

	localparam logic FromDay   = 1'b0;
	localparam logic FromDigits = 1'b1;

	// s_tdata layout, lowest field last
	typedef struct packed {
		logic        pad;
		logic [4:0]  kin;
		logic [4:0]  uinal;
		logic [4:0]  tun;
		logic [4:0]  katun;
		logic [4:0]  baktun;
		logic [21:0] day_number;
	} date_word_t;

	typedef struct packed {
		logic       command;
		date_word_t word;
	} date_item_t;

	// m_tdata layout, lowest field last
	typedef struct packed {
		logic [1:0]  pad;
		logic [3:0]  katun_ahau;
		logic [4:0]  haab_month;
		logic [4:0]  haab_day;
		logic [4:0]  tzolkin_name;
		logic [3:0]  tzolkin_number;
		logic [4:0]  lc_kin;
		logic [4:0]  lc_uinal;
		logic [4:0]  lc_tun;
		logic [4:0]  lc_katun;
		logic [4:0]  lc_baktun;
		logic [21:0] day_out;
	} calendar_word_t;

	typedef struct packed {
		logic           out_of_range;
		calendar_word_t word;
	} calendar_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [47:0] s_tdata = '0;
	logic        s_tuser = 1'b0;
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [71:0] m_tdata;
	logic        m_tuser;

	date_item_t pending_dates[$];
	calendar_t  expected_dates[$];
	date_item_t cur_date;
	calendar_t  want_cal;
	calendar_t  got_cal;
	int         n_dates;
	int         accepted = 0;
	int         results_seen = 0;
	int         mismatches = 0;
	int         tx_gap = 0;
	int         rx_stall = 0;
	int         hold_left = 0;
	int         next_hold_at = 150;
	int unsigned cycle_cnt = 0;
	logic       quiet;

	mayan_calendar_converter_top u_top (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser)
	);

	always #5 clk = ~clk;

	// while cycle_cnt[9:8] is 3, neither side draws a new random gap or stall
	assign quiet = (cycle_cnt[9:8] == 2'b11);

	function automatic longint floor_mod(input longint a, input longint m);
		longint r;
		r = a % m;
		if (r < 0)
			r += m;
		return r;
	endfunction

	function automatic longint floor_div(input longint a, input longint m);
		return (a - floor_mod(a, m)) / m;
	endfunction

	function automatic calendar_t convert_date(input date_item_t it);
		calendar_t c;
		longint    day;
		longint    lc;
		longint    h;
		longint    tuns;
		longint    katuns;
		if (it.command == FromDay) begin
			day = longint'($signed(it.word.day_number));
		end else begin
			day = longint'(it.word.baktun) * BaktunDays + longint'(it.word.katun) * KatunDays
				+ longint'(it.word.tun) * TunDays + longint'(it.word.uinal) * UinalDays
				+ longint'(it.word.kin) - EpochDays;
		end
		lc = day + EpochDays;
		c = '0;
		c.word.day_out        = 22'(day);
		c.word.lc_baktun      = 5'(floor_mod(floor_div(lc, BaktunDays), 20));
		c.word.lc_katun       = 5'(floor_mod(floor_div(lc, KatunDays), 20));
		c.word.lc_tun         = 5'(floor_mod(floor_div(lc, TunDays), 20));
		c.word.lc_uinal       = 5'(floor_mod(floor_div(lc, UinalDays), 18));
		c.word.lc_kin         = 5'(floor_mod(lc, 20));
		c.word.tzolkin_number = 4'(floor_mod(day - 4, 13) + 1);
		c.word.tzolkin_name   = 5'(floor_mod(day + 1, 20));
		h = floor_mod(day + 150, 365);
		c.word.haab_day       = 5'(h % 20);
		c.word.haab_month     = 5'(h / 20);
		// a zero tun, uinal and kin still belongs to the katun that ends there
		tuns = floor_div(lc, TunDays);
		if (floor_mod(lc, TunDays) == 0)
			tuns -= 1;
		katuns = floor_div(tuns, 20);
		c.word.katun_ahau = 4'(floor_mod(floor_mod(katuns, 13) * KatunDays + 1, 13) + 1);
		c.out_of_range = (lc < 0 || lc >= CountSpan);
		return c;
	endfunction

	function automatic int gap_len();
		int r;
		r = $urandom_range(0, 99);
		if (r < 55)
			return 0;
		else if (r < 90)
			return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	function automatic date_item_t day_date(input longint day);
		date_item_t it;
		it = '0;
		it.command = FromDay;
		it.word.day_number = 22'(day);
		return it;
	endfunction

	function automatic date_item_t count_date(input int b, input int k, input int t,
			input int u, input int d);
		date_item_t it;
		it = '0;
		it.command = FromDigits;
		it.word.baktun = 5'(b);
		it.word.katun  = 5'(k);
		it.word.tun    = 5'(t);
		it.word.uinal  = 5'(u);
		it.word.kin    = 5'(d);
		return it;
	endfunction

	function automatic date_item_t random_date();
		date_item_t it;
		int         r;
		r = $urandom_range(0, 99);
		// unused fields carry noise
		it.word.pad        = 1'b0;
		it.word.day_number = 22'($urandom);
		it.word.baktun     = 5'($urandom);
		it.word.katun      = 5'($urandom);
		it.word.tun        = 5'($urandom);
		it.word.uinal      = 5'($urandom);
		it.word.kin        = 5'($urandom);
		if (r < 45) begin
			it.command = FromDay;
			it.word.day_number = 22'(longint'($urandom_range(0, CountSpan - 1)) - EpochDays);
		end else if (r < 55) begin
			it.command = FromDay;
		end else if (r < 90) begin
			it.command = FromDigits;
			it.word.baktun = 5'($urandom_range(0, 19));
			it.word.katun  = 5'($urandom_range(0, 19));
			it.word.tun    = 5'($urandom_range(0, 19));
			it.word.uinal  = 5'($urandom_range(0, 17));
			it.word.kin    = 5'($urandom_range(0, 19));
			if (r < 65) begin
				it.word.uinal = '0;
				it.word.kin   = '0;
				if (r < 60)
					it.word.tun = '0;
			end
		end else begin
			it.command = FromDigits;
		end
		return it;
	endfunction

	task automatic check_field(input string name, input longint want, input longint got);
		if (want != got) begin
			mismatches++;
			$display("%0t: %s expected %0d actual %0d", $time, name, want, got);
		end
	endtask

	// sender: presents queued dates, idles between them at random
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s_tvalid <= 1'b0;
			tx_gap   <= 0;
		end else begin
			if (s_tvalid && s_tready) begin
				expected_dates.push_back(convert_date(cur_date));
				accepted++;
			end
			if (!s_tvalid || s_tready) begin
				if (tx_gap != 0) begin
					tx_gap   <= tx_gap - 1;
					s_tvalid <= 1'b0;
				end else if (pending_dates.size() != 0) begin
					cur_date = pending_dates.pop_front();
					s_tdata  <= cur_date.word;
					s_tuser  <= cur_date.command;
					s_tvalid <= 1'b1;
					tx_gap   <= quiet ? 0 : gap_len();
				end else begin
					s_tvalid <= 1'b0;
				end
			end
		end
	end

	// long receiver hold-offs so the pipeline fills and s_tready drops
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hold_left    <= 0;
			next_hold_at <= 150;
			cycle_cnt    <= 0;
		end else begin
			cycle_cnt <= cycle_cnt + 1;
			if (hold_left != 0) begin
				hold_left <= hold_left - 1;
			end else if (results_seen >= next_hold_at) begin
				hold_left    <= HoldCycles;
				next_hold_at <= next_hold_at + 700;
			end
		end
	end

	// receiver: checks each result item against the oldest prediction
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tready     <= 1'b0;
			rx_stall     <= 0;
			results_seen <= 0;
		end else begin
			if (m_tvalid && m_tready) begin
				results_seen <= results_seen + 1;
				got_cal.word         = m_tdata;
				got_cal.out_of_range = m_tuser;
				if (expected_dates.size() == 0) begin
					mismatches++;
					$display("%0t: result with none expected, expected none actual %h", $time,
						got_cal);
				end else begin
					want_cal = expected_dates.pop_front();
					check_field("day_out", want_cal.word.day_out, got_cal.word.day_out);
					check_field("lc_baktun", want_cal.word.lc_baktun, got_cal.word.lc_baktun);
					check_field("lc_katun", want_cal.word.lc_katun, got_cal.word.lc_katun);
					check_field("lc_tun", want_cal.word.lc_tun, got_cal.word.lc_tun);
					check_field("lc_uinal", want_cal.word.lc_uinal, got_cal.word.lc_uinal);
					check_field("lc_kin", want_cal.word.lc_kin, got_cal.word.lc_kin);
					check_field("tzolkin_number", want_cal.word.tzolkin_number,
						got_cal.word.tzolkin_number);
					check_field("tzolkin_name", want_cal.word.tzolkin_name,
						got_cal.word.tzolkin_name);
					check_field("haab_day", want_cal.word.haab_day, got_cal.word.haab_day);
					check_field("haab_month", want_cal.word.haab_month, got_cal.word.haab_month);
					check_field("katun_ahau", want_cal.word.katun_ahau, got_cal.word.katun_ahau);
					check_field("out_of_range", want_cal.out_of_range, got_cal.out_of_range);
				end
			end
			if (rx_stall != 0) begin
				rx_stall <= rx_stall - 1;
				m_tready <= 1'b0;
			end else if (hold_left != 0) begin
				m_tready <= 1'b0;
			end else if (!quiet && $urandom_range(0, 7) == 0) begin
				rx_stall <= gap_len();
				m_tready <= 1'b0;
			end else begin
				m_tready <= 1'b1;
			end
		end
	end

	initial begin
		// epoch, last five-digit day and the days just outside
		pending_dates.push_back(day_date(-EpochDays));
		pending_dates.push_back(day_date(CountSpan - 1 - EpochDays));
		pending_dates.push_back(day_date(CountSpan - EpochDays));
		pending_dates.push_back(day_date(-EpochDays - 1));
		// field extremes and sign boundary
		pending_dates.push_back(day_date(-2097152));
		pending_dates.push_back(day_date(2097151));
		pending_dates.push_back(day_date(0));
		pending_dates.push_back(day_date(-1));
		// negative count on a tun boundary
		pending_dates.push_back(day_date(-EpochDays - TunDays));
		// first day of wayeb and last day of the year
		pending_dates.push_back(day_date(210));
		pending_dates.push_back(day_date(214));
		pending_dates.push_back(count_date(0, 0, 0, 0, 0));
		pending_dates.push_back(count_date(19, 19, 19, 17, 19));
		pending_dates.push_back(count_date(13, 0, 0, 0, 0));
		pending_dates.push_back(count_date(12, 19, 0, 0, 0));
		pending_dates.push_back(count_date(9, 5, 0, 0, 1));
		pending_dates.push_back(count_date(9, 5, 0, 1, 0));
		pending_dates.push_back(count_date(19, 19, 0, 0, 0));
		pending_dates.push_back(count_date(1, 1, 1, 1, 1));
		// digits above their base, sum wider than the day field
		pending_dates.push_back(count_date(31, 31, 31, 31, 31));
		pending_dates.push_back(count_date(0, 20, 20, 18, 20));
		for (int i = 0; i < RandomDates; i++)
			pending_dates.push_back(random_date());
		n_dates = pending_dates.size();

		repeat (12) @(posedge clk);
		arst_n <= 1'b1;

		while (accepted < n_dates || expected_dates.size() != 0)
			@(posedge clk);
		repeat (DrainCycles) @(posedge clk);
		if (mismatches == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

	initial begin
		#10_000_000;
		$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule
